// ===== rtl/core/pht_pkg.sv =====
`default_nettype none
package pht_pkg;

   // Table geometry.
   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   // Expiry limit in milliseconds.
   localparam int MS_PER_SECOND = 1000;
   localparam int EXPIRY_RESET  = 30;
   localparam int LIMIT_W       = 26;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(EXPIRY_RESET * MS_PER_SECOND);

   // Action codes.
   localparam logic [2:0] ACT_ANNOUNCE = 3'd0;
   localparam logic [2:0] ACT_TICK     = 3'd1;
   localparam logic [2:0] ACT_FORWARD  = 3'd2;
   localparam logic [2:0] ACT_REPLY    = 3'd3;
   localparam logic [2:0] ACT_REVOKE   = 3'd4;

   // Status codes.
   localparam logic [2:0] ST_ADDED     = 3'd0;
   localparam logic [2:0] ST_REFRESHED = 3'd1;
   localparam logic [2:0] ST_COLLISION = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_FOUND     = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND = 3'd5;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_FINISH,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [31:0] overlay;
      logic [31:0] lan;
      logic [15:0] port;
      logic [47:0] last_seen;
      logic        live;
      logic [31:0] forwards;
      logic [31:0] replies;
   } entry_type;

   typedef struct packed {
      logic overlay_eq;
      logic lan_eq;
      logic port_eq;
      logic expired;
   } match_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (&v) ? v : v + 32'd1;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pht_ram.sv =====
`default_nettype none
module pht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/core/pht_match.sv =====
`default_nettype none
module pht_match (
   input  wire pht_pkg::entry_type             entry,
   input  wire logic [31:0]                    overlay_addr,
   input  wire logic [31:0]                    lan_addr,
   input  wire logic [15:0]                    game_port,
   input  wire logic [47:0]                    now_ms,
   input  wire logic [pht_pkg::LIMIT_W-1:0]    limit,
   output pht_pkg::match_type                  match
);

   logic signed [48:0] age;

   // Signed age, so a clock that runs backwards never expires an entry.
   assign age = $signed({1'b0, now_ms}) - $signed({1'b0, entry.last_seen});

   assign match.overlay_eq = (entry.overlay == overlay_addr);
   assign match.lan_eq     = (entry.lan == lan_addr);
   assign match.port_eq    = (entry.port == game_port);
   assign match.expired    = age > $signed({(49 - pht_pkg::LIMIT_W)'(0), limit});

endmodule
`default_nettype wire

// ===== rtl/core/peer_host_table.sv =====
// Peer host table: an ordered table of up to sixteen peers.
// Input channel (req_*): one transfer carries an action with its addresses,
// port and time. The block stalls the request side while it works on an item.
// Result channel (rsp_*): one transfer per item with the status, the running
// collision count and the entry count after the item.
// Configuration: csr_wdata is taken as the expiry time in seconds at any edge
// with csr_wen high; write it only while the block is idle.
// Sequencing: the sequencer walks the stored entries through the single read
// port of the entry RAM, with a read step and an evaluate step per entry, then
// a finishing step and the result step. The next request is taken in the
// cycle after the result transfer. Refresh and reply items stop at the first
// match. Unknown actions skip the walk and the finishing step and go straight
// to the result.
// Only one item is in flight at a time.
// Reset empties the table, clears the collision count and sets the expiry
// to 30 seconds. While the receiver stalls, the result stays on the rsp_ ports
// and no new request is taken.
`default_nettype none
module peer_host_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_action,
   input  wire logic [31:0] req_overlay_addr,
   input  wire logic [31:0] req_lan_addr,
   input  wire logic [15:0] req_game_port,
   input  wire logic [47:0] req_now_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_collision_total,
   output logic [4:0]       rsp_entry_count,
   input  wire logic        csr_wen,
   input  wire logic [15:0] csr_wdata
);

   pht_pkg::state_type state_ff, state_in;
   logic [pht_pkg::CNT_W-1:0]   idx_ff, idx_in;
   logic [pht_pkg::CNT_W-1:0]   wr_ff, wr_in;
   logic [pht_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [31:0]                 coll_ff, coll_in;
   logic [2:0]                  status_ff, status_in;
   logic                        flag_ff, flag_in;
   logic [pht_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic [2:0]                  act_ff;
   logic [31:0]                 ov_ff, lan_ff;
   logic [15:0]                 port_ff;
   logic [47:0]                 now_ff;

   logic                        ram_we;
   logic [pht_pkg::IDX_W-1:0]   ram_waddr;
   pht_pkg::entry_type          ram_wdata, ram_rdata;
   pht_pkg::match_type          match;
   logic                        last;
   logic                        accept;

   assign accept = req_valid && !req_stall;
   assign last   = (idx_ff + pht_pkg::CNT_W'(1)) == cnt_ff;

   pht_ram #(
      .WIDTH ($bits(pht_pkg::entry_type)),
      .DEPTH (pht_pkg::MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff[pht_pkg::IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   pht_match u_match (
      .entry        (ram_rdata),
      .overlay_addr (ov_ff),
      .lan_addr     (lan_ff),
      .game_port    (port_ff),
      .now_ms       (now_ff),
      .limit        (limit_ff),
      .match        (match)
   );

   // Expiry limit in milliseconds, formed once per configuration write.
   assign limit_in = csr_wen ? pht_pkg::LIMIT_W'({10'd0, csr_wdata} *
                                                 pht_pkg::LIMIT_W'(pht_pkg::MS_PER_SECOND))
                             : limit_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pht_pkg::S_IDLE;
         cnt_ff   <= '0;
         coll_ff  <= '0;
         limit_ff <= pht_pkg::LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         coll_ff  <= coll_in;
         limit_ff <= limit_in;
      end
   end

   // Working registers and the latched request.
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      wr_ff     <= wr_in;
      status_ff <= status_in;
      flag_ff   <= flag_in;
      if (accept) begin
         act_ff  <= req_action;
         ov_ff   <= req_overlay_addr;
         lan_ff  <= req_lan_addr;
         port_ff <= req_game_port;
         now_ff  <= req_now_ms;
      end
   end

   // Sequencer: one stored entry per read and evaluate pair.
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      wr_in     = wr_ff;
      cnt_in    = cnt_ff;
      coll_in   = coll_ff;
      status_in = status_ff;
      flag_in   = flag_ff;
      ram_we    = 1'b0;
      ram_waddr = idx_ff[pht_pkg::IDX_W-1:0];
      ram_wdata = ram_rdata;
      case (state_ff)
         pht_pkg::S_IDLE: begin
            if (accept) begin
               idx_in  = '0;
               wr_in   = '0;
               flag_in = 1'b0;
               if (req_action > pht_pkg::ACT_REVOKE) begin
                  status_in = pht_pkg::ST_NOT_FOUND;
                  state_in  = pht_pkg::S_RESP;
               end else if (cnt_ff == '0) begin
                  state_in = pht_pkg::S_FINISH;
               end else begin
                  state_in = pht_pkg::S_READ;
               end
            end
         end
         pht_pkg::S_READ: begin
            state_in = pht_pkg::S_EVAL;
         end
         pht_pkg::S_EVAL: begin
            state_in = last ? pht_pkg::S_FINISH : pht_pkg::S_READ;
            idx_in   = idx_ff + pht_pkg::CNT_W'(1);
            case (act_ff)
               pht_pkg::ACT_ANNOUNCE: begin
                  if (match.overlay_eq) begin
                     ram_we              = 1'b1;
                     ram_wdata.lan       = lan_ff;
                     ram_wdata.port      = port_ff;
                     ram_wdata.last_seen = now_ff;
                     ram_wdata.live      = 1'b1;
                     status_in           = pht_pkg::ST_REFRESHED;
                     state_in            = pht_pkg::S_RESP;
                  end else if (ram_rdata.live && match.lan_eq && match.port_eq) begin
                     flag_in = 1'b1;
                  end
               end
               pht_pkg::ACT_TICK: begin
                  if (match.expired) begin
                     ram_we         = 1'b1;
                     ram_wdata.live = 1'b0;
                  end
               end
               pht_pkg::ACT_FORWARD: begin
                  if (match.lan_eq) begin
                     ram_we              = 1'b1;
                     ram_wdata.forwards  = pht_pkg::sat_inc(ram_rdata.forwards);
                     ram_wdata.last_seen = now_ff;
                     flag_in             = 1'b1;
                  end
               end
               pht_pkg::ACT_REPLY: begin
                  if (match.lan_eq && match.port_eq) begin
                     ram_we            = 1'b1;
                     ram_wdata.replies = pht_pkg::sat_inc(ram_rdata.replies);
                     status_in         = pht_pkg::ST_FOUND;
                     state_in          = pht_pkg::S_RESP;
                  end
               end
               default: begin
                  // Revoke: keep entries that differ, packing them down.
                  if (!match.overlay_eq) begin
                     ram_we    = (wr_ff != idx_ff);
                     ram_waddr = wr_ff[pht_pkg::IDX_W-1:0];
                     wr_in     = wr_ff + pht_pkg::CNT_W'(1);
                  end
               end
            endcase
         end
         pht_pkg::S_FINISH: begin
            state_in = pht_pkg::S_RESP;
            case (act_ff)
               pht_pkg::ACT_ANNOUNCE: begin
                  if (flag_ff) begin
                     coll_in   = pht_pkg::sat_inc(coll_ff);
                     status_in = pht_pkg::ST_COLLISION;
                  end else if (cnt_ff >= pht_pkg::CNT_W'(pht_pkg::MAX_ENTRIES)) begin
                     status_in = pht_pkg::ST_FULL;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = cnt_ff[pht_pkg::IDX_W-1:0];
                     ram_wdata = '{overlay: ov_ff, lan: lan_ff, port: port_ff,
                                   last_seen: now_ff, live: 1'b1,
                                   forwards: 32'd0, replies: 32'd0};
                     cnt_in    = cnt_ff + pht_pkg::CNT_W'(1);
                     status_in = pht_pkg::ST_ADDED;
                  end
               end
               pht_pkg::ACT_TICK: begin
                  status_in = pht_pkg::ST_ADDED;
               end
               pht_pkg::ACT_FORWARD: begin
                  status_in = flag_ff ? pht_pkg::ST_FOUND : pht_pkg::ST_NOT_FOUND;
               end
               pht_pkg::ACT_REPLY: begin
                  status_in = pht_pkg::ST_NOT_FOUND;
               end
               default: begin
                  if (wr_ff == cnt_ff) begin
                     status_in = pht_pkg::ST_NOT_FOUND;
                  end else begin
                     cnt_in    = wr_ff;
                     status_in = pht_pkg::ST_FOUND;
                  end
               end
            endcase
         end
         pht_pkg::S_RESP: begin
            if (!rsp_stall) begin
               state_in = pht_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pht_pkg::S_IDLE;
         end
      endcase
   end

   assign req_stall           = (state_ff != pht_pkg::S_IDLE);
   assign rsp_valid           = (state_ff == pht_pkg::S_RESP);
   assign rsp_status          = status_ff;
   assign rsp_collision_total = coll_ff;
   assign rsp_entry_count     = 5'(cnt_ff);

   // The table never holds more entries than it has room for.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= pht_pkg::CNT_W'(pht_pkg::MAX_ENTRIES))
      else $error("entry count beyond table size");

   // A result transfer returns the block to idle.
   a_resp_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid && !req_stall)
      else $error("result held after transfer");

   // The collision count never goes down.
   a_coll_mono: assert property (@(posedge clock) disable iff (reset)
      ##1 coll_ff >= $past(coll_ff))
      else $error("collision count decreased");

   // The entry count changes only in the finishing step.
   a_count_change: assert property (@(posedge clock) disable iff (reset)
      state_ff != pht_pkg::S_FINISH |=> cnt_ff == $past(cnt_ff))
      else $error("entry count changed outside finish");

endmodule
`default_nettype wire

// ===== test/tb_peer_host_table.sv =====
`default_nettype none
module tb_peer_host_table;
   timeunit 1ns;
   timeprecision 1ps;

   // Clock, reset and block ports.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action = pht_pkg::ACT_TICK;
   logic [31:0] req_overlay_addr = '0;
   logic [31:0] req_lan_addr = '0;
   logic [15:0] req_game_port = '0;
   logic [47:0] req_now_ms = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_collision_total;
   logic [4:0]  rsp_entry_count;
   logic        csr_wen = 1'b0;
   logic [15:0] csr_wdata = '0;

   peer_host_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_action(req_action), .req_overlay_addr(req_overlay_addr),
      .req_lan_addr(req_lan_addr), .req_game_port(req_game_port),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_collision_total(rsp_collision_total),
      .rsp_entry_count(rsp_entry_count),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the peer table.
   typedef struct {
      logic [31:0] overlay;
      logic [31:0] lan;
      logic [15:0] port;
      logic [47:0] seen;
      bit          live;
      logic [31:0] forwards;
      logic [31:0] replies;
   } peer_type;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] collisions;
      logic [4:0]  count;
   } outcome_type;

   peer_type    peers[pht_pkg::MAX_ENTRIES];
   int unsigned peer_count = 0;
   logic [31:0] collision_seen = '0;
   logic [15:0] expiry_secs = 16'(pht_pkg::EXPIRY_RESET);

   // Outcomes waiting for their result transfer, oldest first.
   outcome_type pending_outcomes[64];
   int          put_count = 0;
   int          take_count = 0;

   int error_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_request = 1'b0;
   int hold_left = 0;

   // Per-phase value pools, kept small so that addresses collide often.
   logic [31:0] overlay_pool[24];
   logic [31:0] lan_pool[6];
   logic [15:0] port_pool[3];
   logic [47:0] clock_ms = 48'd100000;

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (&v) ? v : v + 32'd1;
   endfunction

   // Works out the outcome of one item and updates the shadow table.
   function automatic outcome_type peer_table_update(input logic [2:0] action,
         input logic [31:0] ov, input logic [31:0] lan, input logic [15:0] port,
         input logic [47:0] now);
      outcome_type o;
      longint limit;
      longint age;
      int wr;
      bit hit;
      o.status = pht_pkg::ST_NOT_FOUND;
      hit = 1'b0;
      case (action)
         pht_pkg::ACT_ANNOUNCE: begin
            for (int i = 0; i < peer_count && !hit; i++) begin
               if (peers[i].overlay == ov) begin
                  peers[i].lan = lan;
                  peers[i].port = port;
                  peers[i].seen = now;
                  peers[i].live = 1'b1;
                  o.status = pht_pkg::ST_REFRESHED;
                  hit = 1'b1;
               end
            end
            for (int i = 0; i < peer_count && !hit; i++) begin
               if (peers[i].live && peers[i].lan == lan && peers[i].port == port) begin
                  collision_seen = bump(collision_seen);
                  o.status = pht_pkg::ST_COLLISION;
                  hit = 1'b1;
               end
            end
            if (!hit) begin
               if (peer_count >= pht_pkg::MAX_ENTRIES) begin
                  o.status = pht_pkg::ST_FULL;
               end else begin
                  peers[peer_count] = '{ov, lan, port, now, 1'b1, 32'd0, 32'd0};
                  peer_count++;
                  o.status = pht_pkg::ST_ADDED;
               end
            end
         end
         pht_pkg::ACT_TICK: begin
            limit = longint'(expiry_secs) * pht_pkg::MS_PER_SECOND;
            for (int i = 0; i < peer_count; i++) begin
               age = longint'({16'd0, now}) - longint'({16'd0, peers[i].seen});
               if (age > limit) peers[i].live = 1'b0;
            end
            o.status = pht_pkg::ST_ADDED;
         end
         pht_pkg::ACT_FORWARD: begin
            for (int i = 0; i < peer_count; i++) begin
               if (peers[i].lan == lan) begin
                  peers[i].forwards = bump(peers[i].forwards);
                  peers[i].seen = now;
                  o.status = pht_pkg::ST_FOUND;
               end
            end
         end
         pht_pkg::ACT_REPLY: begin
            for (int i = 0; i < peer_count && !hit; i++) begin
               if (peers[i].lan == lan && peers[i].port == port) begin
                  peers[i].replies = bump(peers[i].replies);
                  o.status = pht_pkg::ST_FOUND;
                  hit = 1'b1;
               end
            end
         end
         pht_pkg::ACT_REVOKE: begin
            wr = 0;
            for (int i = 0; i < peer_count; i++) begin
               if (peers[i].overlay != ov) begin
                  peers[wr] = peers[i];
                  wr++;
               end
            end
            if (wr != peer_count) o.status = pht_pkg::ST_FOUND;
            peer_count = wr;
         end
         default: o.status = pht_pkg::ST_NOT_FOUND;
      endcase
      o.collisions = collision_seen;
      o.count = 5'(peer_count);
      return o;
   endfunction

   // Offers one item and waits for its transfer, then records the outcome.
   task automatic send_item(input logic [2:0] action, input logic [31:0] ov,
         input logic [31:0] lan, input logic [15:0] port, input logic [47:0] now);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_overlay_addr <= ov;
      req_lan_addr <= lan;
      req_game_port <= port;
      req_now_ms <= now;
      do @(posedge clock); while (req_stall);
      pending_outcomes[put_count % 64] = peer_table_update(action, ov, lan, port, now);
      put_count++;
   endtask

   // Drains all results, then writes the expiry register while idle.
   task automatic write_expiry(input logic [15:0] secs);
      req_valid <= 1'b0;
      @(posedge clock);
      while (put_count != take_count) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= secs;
      @(posedge clock);
      csr_wen <= 1'b0;
      expiry_secs = secs;
   endtask

   // Receiver stall, with an optional long hold-off.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Result checker: every transfer is compared with the oldest outcome.
   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (put_count == take_count) begin
            $error("result transfer with no outstanding item");
            error_count++;
         end else begin
            e = pending_outcomes[take_count % 64];
            take_count++;
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_status);
               error_count++;
            end
            if (rsp_collision_total !== e.collisions) begin
               $error("collision_total: expected %0d, got %0d",
                      e.collisions, rsp_collision_total);
               error_count++;
            end
            if (rsp_entry_count !== e.count) begin
               $error("entry_count: expected %0d, got %0d", e.count, rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   function automatic logic [47:0] random48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   task automatic refill_pools();
      foreach (overlay_pool[i]) overlay_pool[i] = $urandom;
      foreach (lan_pool[i]) lan_pool[i] = $urandom;
      foreach (port_pool[i]) port_pool[i] = 16'($urandom);
   endtask

   // Directed corner cases: extremes, every action, expiry, full table.
   task automatic test_directed();
      send_item(pht_pkg::ACT_REVOKE, 32'd1, 32'd0, 16'd0, 48'd0);
      send_item(pht_pkg::ACT_ANNOUNCE, 32'd0, 32'd0, 16'd0, 48'd0);
      send_item(pht_pkg::ACT_ANNOUNCE, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF,
                48'hFFFFFFFFFFFF);
      send_item(pht_pkg::ACT_ANNOUNCE, 32'd5, 32'hFFFFFFFF, 16'hFFFF, 48'd10);
      send_item(pht_pkg::ACT_ANNOUNCE, 32'd0, 32'd7, 16'd9, 48'd1000);
      send_item(pht_pkg::ACT_FORWARD, 32'd0, 32'd7, 16'd0, 48'd2000);
      send_item(pht_pkg::ACT_FORWARD, 32'd0, 32'd8, 16'd0, 48'd2000);
      send_item(pht_pkg::ACT_REPLY, 32'd0, 32'd7, 16'd9, 48'd0);
      send_item(pht_pkg::ACT_REPLY, 32'd0, 32'd7, 16'd8, 48'd0);
      // Time going backwards never expires; a late tick ages entries out.
      send_item(pht_pkg::ACT_TICK, 32'd0, 32'd0, 16'd0, 48'd0);
      send_item(pht_pkg::ACT_TICK, 32'd0, 32'd0, 16'd0, 48'd32001);
      send_item(pht_pkg::ACT_ANNOUNCE, 32'd6, 32'd7, 16'd9, 48'd32001);
      send_item(pht_pkg::ACT_TICK, 32'd0, 32'd0, 16'd0, 48'hFFFFFFFFFFFF);
      send_item(pht_pkg::ACT_ANNOUNCE, 32'd7, 32'd7, 16'd9, 48'd5);
      send_item(3'd5, 32'd0, 32'd0, 16'd0, 48'd0);
      send_item(3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 48'hFFFFFFFFFFFF);
      for (int i = 0; i < 13; i++) send_item(pht_pkg::ACT_ANNOUNCE, 32'd100 + i,
                                              32'd200 + i, 16'd1, 48'd50);
      send_item(pht_pkg::ACT_ANNOUNCE, 32'd999, 32'd999, 16'd1, 48'd50);
      send_item(pht_pkg::ACT_REVOKE, 32'd100, 32'd0, 16'd0, 48'd0);
      send_item(pht_pkg::ACT_REVOKE, 32'hFFFFFFFF, 32'd0, 16'd0, 48'd0);
   endtask

   // Random phase: mostly pooled traffic, some fully random noise.
   task automatic test_random(input int items, input int expiry_span_ms,
         input bit with_hold);
      int pick;
      logic [2:0] act;
      refill_pools();
      for (int k = 0; k < items; k++) begin
         if (with_hold && k == items / 3) hold_request = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_item(3'($urandom), $urandom, $urandom, 16'($urandom), random48());
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 40) act = pht_pkg::ACT_ANNOUNCE;
            else if (pick < 55) act = pht_pkg::ACT_TICK;
            else if (pick < 70) act = pht_pkg::ACT_FORWARD;
            else if (pick < 85) act = pht_pkg::ACT_REPLY;
            else if (pick < 97) act = pht_pkg::ACT_REVOKE;
            else act = 3'($urandom_range(5, 7));
            if ($urandom_range(0, 9) == 0)
               clock_ms = clock_ms - 48'($urandom_range(0, expiry_span_ms));
            else
               clock_ms = clock_ms + 48'($urandom_range(0, expiry_span_ms / 4));
            send_item(act, overlay_pool[$urandom_range(0, 23)],
                      lan_pool[$urandom_range(0, 5)], port_pool[$urandom_range(0, 2)],
                      clock_ms);
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 18;
      recv_idle_pct = 64;
      test_directed();
      write_expiry(16'd1);
      test_random(580, 3000, 1'b1);
      send_idle_pct = 64;
      recv_idle_pct = 18;
      write_expiry(16'hFFFF);
      test_random(580, 200000000, 1'b0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_expiry(16'd7);
      test_random(590, 20000, 1'b1);
      req_valid <= 1'b0;
      while (put_count != take_count) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0 && put_count == take_count) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/pht_pkg.sv
rtl/core/pht_ram.sv
rtl/core/pht_match.sv
rtl/core/peer_host_table.sv
test/tb_peer_host_table.sv
